@@ rtl/plst_pkg.sv @@
`timescale 1ns / 1ps

package plst_pkg;

  // default sizing of the list
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed field widths of the stream words
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // operation codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } plst_op_t;

  // status codes carried in the output tuser
  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADPOS = 2'd2,
    STS_EMPTY  = 2'd3
  } plst_status_t;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ROTATE = 2'd3
  } plst_cmd_t;

  // control states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } plst_state_t;

endpackage

@@ rtl/plst_cell.sv @@
`timescale 1ns / 1ps

module plst_cell #(
  parameter int unsigned CAPACITY   = plst_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF,
  parameter int unsigned SLOT       = 0,
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  plst_pkg::plst_cmd_t   cmd,
  input  logic [CW-1:0]         sel_idx,
  input  logic [CW-1:0]         cnt,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] head_word,
  output logic [DATA_WIDTH-1:0] word_q
);

  localparam logic [CW:0] SLOT_C    = (CW + 1)'(SLOT);
  localparam logic [CW:0] SLOT_P1_C = (CW + 1)'(SLOT + 1);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;
  logic [CW:0]           idx_x;
  logic [CW:0]           cnt_x;

  assign idx_x = {1'b0, sel_idx};
  assign cnt_x = {1'b0, cnt};

  // pick this slot's next word from its neighbors, the new word or the head word
  always_comb begin
    word_nxt = word_r;
    unique case (cmd)
      plst_pkg::CMD_INSERT: begin
        if (SLOT_C == idx_x) begin
          word_nxt = new_word;
        end else if (SLOT_C > idx_x && SLOT_C <= cnt_x) begin
          word_nxt = left_word;
        end
      end
      plst_pkg::CMD_REMOVE: begin
        if (SLOT_C >= idx_x && SLOT_P1_C < cnt_x) begin
          word_nxt = right_word;
        end
      end
      plst_pkg::CMD_ROTATE: begin
        if (SLOT_P1_C < cnt_x) begin
          word_nxt = right_word;
        end else if (SLOT_P1_C == cnt_x) begin
          word_nxt = head_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // slot storage
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

@@ rtl/positional_list_store_core.sv @@
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)              tuser           tlast
// in_      in   position[4:0], value[36:5]       operation[1:0]  -
// out_     out  data[31:0], length[36:32]        status[1:0]     last
//
// append, insert and remove shift the chain and register the result on the
// accepting edge. a dump of a non-empty list first enters the dump state, then
// sends one word per cycle while the output is not stalled, as the chain rotates
// so the head cell holds the next word.
// reset clears the count and control only; slot contents stay as they are.
// output stalls freeze a dump; a new word waits for idle control and a free output slot.
module positional_list_store_core #(
  parameter int unsigned CAPACITY   = plst_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [plst_pkg::IN_TDATA_W-1:0]    in_tdata,   // position, value
  input  logic [plst_pkg::OP_W-1:0]          in_tuser,   // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [plst_pkg::OUT_TDATA_W-1:0]   out_tdata,  // data, length
  output logic [plst_pkg::STATUS_W-1:0]      out_tuser,  // status
  output logic                               out_tlast
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W;
  localparam int unsigned VAL_W = plst_pkg::VAL_W;

  // input fields
  plst_pkg::plst_op_t            in_op;
  logic [plst_pkg::POS_W-1:0]    in_pos;
  logic [VAL_W-1:0]              in_value;

  assign in_op    = plst_pkg::plst_op_t'(in_tuser);
  assign in_pos   = in_tdata[plst_pkg::POS_W-1:0];
  assign in_value = in_tdata[plst_pkg::POS_W +: VAL_W];

  // control registers
  plst_pkg::plst_state_t state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]               out_data_r, out_data_nxt;
  logic [plst_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  plst_pkg::plst_status_t         out_sts_r, out_sts_nxt;
  logic                           out_last_r, out_last_nxt;

  // chain control
  plst_pkg::plst_cmd_t   cmd;
  logic [CW-1:0]         sel_idx;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  logic                  slot_free;
  logic                  in_fire;
  logic                  is_full;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      ins_idx;
  logic [CMP_W-1:0]      rem_idx;
  logic [DATA_WIDTH-1:0] picked;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == plst_pkg::ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  assign is_full   = (count_r == CW'(CAPACITY));
  assign pos_x     = CMP_W'(in_pos);
  assign cnt_x     = CMP_W'(count_r);
  assign ins_idx   = cnt_x - pos_x;
  assign rem_idx   = cnt_x - CMP_W'(1) - pos_x;
  assign new_word  = DATA_WIDTH'($signed(in_value));
  assign picked    = cell_q[rem_idx[IW-1:0]];

  // chain of slots, head at slot 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    plst_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .SLOT       (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel_idx    (sel_idx),
      .cnt        (count_r),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (cell_q[0]),
      .word_q     (cell_q[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plst_pkg::ST_IDLE: begin
        if (in_fire && in_op == plst_pkg::OP_DUMP && count_r != '0) begin
          state_nxt = plst_pkg::ST_DUMP;
        end
      end
      plst_pkg::ST_DUMP: begin
        if (slot_free && rem_r == CW'(1)) begin
          state_nxt = plst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = plst_pkg::ST_IDLE;
      end
    endcase
  end

  // chain commands, count and result words
  always_comb begin
    cmd          = plst_pkg::CMD_HOLD;
    sel_idx      = '0;
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    out_data_nxt = out_data_r;
    out_len_nxt  = out_len_r;
    out_sts_nxt  = out_sts_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      plst_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_sts_nxt   = plst_pkg::STS_OK;
          unique case (in_op)
            plst_pkg::OP_APPEND: begin
              if (is_full) begin
                out_sts_nxt = plst_pkg::STS_FULL;
              end else begin
                cmd       = plst_pkg::CMD_INSERT;
                sel_idx   = count_r;
                count_nxt = count_r + CW'(1);
              end
            end
            plst_pkg::OP_INSERT: begin
              if (is_full) begin
                out_sts_nxt = plst_pkg::STS_FULL;
              end else if (pos_x > cnt_x) begin
                out_sts_nxt = plst_pkg::STS_BADPOS;
              end else begin
                cmd       = plst_pkg::CMD_INSERT;
                sel_idx   = CW'(ins_idx);
                count_nxt = count_r + CW'(1);
              end
            end
            plst_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                out_sts_nxt = plst_pkg::STS_EMPTY;
              end else if (pos_x >= cnt_x) begin
                out_sts_nxt = plst_pkg::STS_BADPOS;
              end else begin
                cmd          = plst_pkg::CMD_REMOVE;
                sel_idx      = CW'(rem_idx);
                count_nxt    = count_r - CW'(1);
                out_data_nxt = VAL_W'($signed(picked));
              end
            end
            plst_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                out_sts_nxt = plst_pkg::STS_EMPTY;
              end else begin
                // words follow from the dump state
                out_valid_nxt = 1'b0;
                rem_nxt       = count_r;
              end
            end
            default: begin
              out_sts_nxt = plst_pkg::STS_OK;
            end
          endcase
          out_len_nxt = plst_pkg::LEN_W'(count_nxt);
        end
      end
      plst_pkg::ST_DUMP: begin
        if (slot_free) begin
          cmd           = plst_pkg::CMD_ROTATE;
          rem_nxt       = rem_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_sts_nxt   = plst_pkg::STS_OK;
          out_data_nxt  = VAL_W'($signed(cell_q[0]));
          out_len_nxt   = plst_pkg::LEN_W'(count_r);
          out_last_nxt  = (rem_r == CW'(1));
        end
      end
      default: begin
        cmd = plst_pkg::CMD_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plst_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_len_r  <= out_len_nxt;
    out_sts_r  <= out_sts_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(plst_pkg::OUT_TDATA_W - VAL_W - plst_pkg::LEN_W)'(0),
                       out_len_r, out_data_r};
  assign out_tuser  = out_sts_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/sv/positional_list_store_core_tb.sv @@
`timescale 1ns / 1ps

module positional_list_store_core_tb;
  import plst_pkg::*;

  localparam int unsigned LIST_CAP     = CAPACITY_DEF;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 400;

  // one command word as the sender holds it
  typedef struct {
    plst_op_t        op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    bit              drain;
  } list_cmd_t;

  // one result word as the list should return it
  typedef struct {
    plst_status_t       status;
    logic [31:0]        data;
    logic [LEN_W-1:0]   length;
    logic               last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // position, value
  logic [OP_W-1:0]        in_tuser = '0;   // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // data, length
  logic [STATUS_W-1:0]    out_tuser;       // status
  logic                   out_tlast;

  list_cmd_t    pending_items[$];
  list_result_t expected_results[$];

  // shadow copy of the list
  logic [31:0] list_words[LIST_CAP];
  int unsigned list_len = 0;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          in_hold;
  bit          in_launch;
  list_result_t got;

  positional_list_store_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch on result %0d: %s", $realtime, words_seen, what);
    mismatch_count++;
  endtask

  task automatic push_result(plst_status_t status, logic [31:0] data, logic last);
    list_result_t r;
    r.status = status;
    r.data   = data;
    r.length = LEN_W'(list_len);
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // apply one command to the shadow list and queue the words it yields
  task automatic apply_list_cmd(plst_op_t op, logic [POS_W-1:0] pos, logic [31:0] value);
    int unsigned slot;
    logic [31:0] removed;
    case (op)
      OP_APPEND: begin
        if (list_len >= LIST_CAP) begin
          push_result(STS_FULL, '0, 1'b1);
        end else begin
          list_words[list_len] = value;
          list_len++;
          push_result(STS_OK, '0, 1'b1);
        end
      end
      OP_INSERT: begin
        if (list_len >= LIST_CAP) begin
          push_result(STS_FULL, '0, 1'b1);
        end else if (pos > list_len) begin
          push_result(STS_BADPOS, '0, 1'b1);
        end else begin
          slot = list_len - pos;
          for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = value;
          list_len++;
          push_result(STS_OK, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (list_len == 0) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else if (pos >= list_len) begin
          push_result(STS_BADPOS, '0, 1'b1);
        end else begin
          slot = list_len - 1 - pos;
          removed = list_words[slot];
          for (int i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          push_result(STS_OK, removed, 1'b1);
        end
      end
      default: begin
        if (list_len == 0) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_result(STS_OK, list_words[i], (i + 1 == list_len));
        end
      end
    endcase
  endtask

  // sender: present queued words, predict on each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_hold = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        apply_list_cmd(plst_op_t'(in_tuser), in_tdata[POS_W-1:0], in_tdata[POS_W+VAL_W-1:POS_W]);
        void'(pending_items.pop_front());
        words_sent++;
        if (words_sent % 48 == 0) in_calm = ($urandom_range(0, 2) == 0);
        in_gap = pick_gap(in_calm);
      end
      if (!in_hold) begin
        in_launch = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          in_launch = !(pending_items[0].drain && expected_results.size() != 0);
        end
        if (in_launch) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_items[0].op;
          in_tdata  <= {3'b000, pending_items[0].value, pending_items[0].pos};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = plst_status_t'(out_tuser);
        got.data   = out_tdata[31:0];
        got.length = out_tdata[32 +: LEN_W];
        got.last   = out_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing outstanding");
        end else begin
          if (got.status !== expected_results[0].status)
            report_mismatch($sformatf("status %0d, want %0d", got.status,
                                      expected_results[0].status));
          if (got.data !== expected_results[0].data)
            report_mismatch($sformatf("data %h, want %h", got.data,
                                      expected_results[0].data));
          if (got.length !== expected_results[0].length)
            report_mismatch($sformatf("length %0d, want %0d", got.length,
                                      expected_results[0].length));
          if (got.last !== expected_results[0].last)
            report_mismatch($sformatf("last %b, want %b", got.last,
                                      expected_results[0].last));
          void'(expected_results.pop_front());
        end
        words_seen++;
        if (words_seen % 64 == 0) out_calm = ($urandom_range(0, 2) == 0);
        out_stall = pick_gap(out_calm);
      end else if (!out_calm && out_stall == 0 && $urandom_range(0, 24) == 0) begin
        out_stall = pick_gap(1'b0);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus build, tracking the expected list length for well-formed positions
  int unsigned gen_len = 0;

  task automatic add_cmd(plst_op_t op, int unsigned pos, logic [31:0] value, bit drain = 1'b0);
    list_cmd_t c;
    c.op    = op;
    c.pos   = POS_W'(pos);
    c.value = value;
    c.drain = drain;
    pending_items.push_back(c);
    case (op)
      OP_APPEND: if (gen_len < LIST_CAP) gen_len++;
      OP_INSERT: if (gen_len < LIST_CAP && c.pos <= gen_len) gen_len++;
      OP_REMOVE: if (gen_len > 0 && c.pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_pos(plst_op_t op);
    if ($urandom_range(0, 99) < 15 || op == OP_APPEND || op == OP_DUMP)
      return $urandom_range(0, 31);
    if (op == OP_INSERT) return $urandom_range(0, gen_len);
    return (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
  endfunction

  initial begin
    int unsigned mode;
    int unsigned r;
    plst_op_t op;

    // directed: empty list corner cases
    add_cmd(OP_DUMP, 0, 32'h0);
    add_cmd(OP_REMOVE, 31, 32'h0);
    add_cmd(OP_INSERT, 1, 32'h1234_5678);
    // fill to capacity with extreme values, position ignored on append
    add_cmd(OP_INSERT, 0, 32'h7fff_ffff);
    add_cmd(OP_APPEND, 31, 32'h8000_0000);
    add_cmd(OP_APPEND, 0, 32'hffff_ffff);
    add_cmd(OP_APPEND, 0, 32'h0000_0000);
    for (int i = 0; i < LIST_CAP - 4; i++) add_cmd(OP_APPEND, i, $urandom);
    // full list: full wins over a bad position; then edge positions on remove and insert
    add_cmd(OP_APPEND, 0, 32'h5555_5555);
    add_cmd(OP_INSERT, 31, 32'haaaa_aaaa);
    add_cmd(OP_DUMP, 31, 32'h0);
    add_cmd(OP_REMOVE, LIST_CAP, 32'h0);
    add_cmd(OP_REMOVE, LIST_CAP - 1, 32'h0);
    add_cmd(OP_INSERT, LIST_CAP, 32'hdead_beef);
    add_cmd(OP_INSERT, LIST_CAP - 1, 32'h0bad_cafe);
    add_cmd(OP_REMOVE, 0, 32'h0);
    add_cmd(OP_DUMP, 0, 32'h0);

    // random: fill, drain and mixed stretches so the list swings end to end
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0:       op = (r < 35) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 90) ? OP_REMOVE : OP_DUMP;
        1:       op = (r < 10) ? OP_APPEND : (r < 25) ? OP_INSERT : (r < 88) ? OP_REMOVE : OP_DUMP;
        default: op = plst_op_t'($urandom_range(0, 3));
      endcase
      add_cmd(op, pick_pos(op), $urandom, (n % 100 == 0));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ positional_list_store_core.f @@
rtl/plst_pkg.sv
rtl/plst_cell.sv
rtl/positional_list_store_core.sv
tb/sv/positional_list_store_core_tb.sv
